>>> sv/cpab_pkg.sv
package cpab_pkg;

  // Frame store geometry.
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
  localparam int X_W        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int Y_W        = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Field widths.
  localparam int CFG_W   = 9;
  localparam int POS_W   = 16;
  localparam int CH_W    = 8;
  localparam int PIX_W   = 4 * CH_W;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  // Command queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Access kinds as they arrive on the input.
  localparam logic [1:0] KIND_SET   = 2'd0;
  localparam logic [1:0] KIND_BLEND = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // Register indexes on the configuration port.
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Reset value of both size registers.
  localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(256);

  // Operation after classification.
  typedef enum logic [1:0] {
    OP_SET,
    OP_BLEND,
    OP_READ,
    OP_CLIP
  } op_t;

  // One queued pixel access.
  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] addr;
    logic [CH_W-1:0]   red;
    logic [CH_W-1:0]   green;
    logic [CH_W-1:0]   blue;
    logic [CH_W-1:0]   alpha;
  } pix_req_t;

  // Back part sequencer.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_MIX,
    ST_OUT
  } back_state_t;

  typedef struct packed {
    logic pop;
    logic mem_rd;
    logic update;
    logic show;
  } back_ctl_t;

  // Fast alpha mix of one channel: ((a+1)*s >> 8) + ((256-a)*d >> 8).
  function automatic logic [CH_W-1:0] mix_channel(input logic [CH_W-1:0] a,
                                                  input logic [CH_W-1:0] s,
                                                  input logic [CH_W-1:0] d);
    logic [CH_W:0]     wa;
    logic [CH_W:0]     wd;
    logic [2*CH_W:0]   ps;
    logic [2*CH_W:0]   pd;
    logic [CH_W:0]     sum;
    wa  = {1'b0, a} + (CH_W+1)'(1);
    wd  = (CH_W+1)'(256) - {1'b0, a};
    ps  = (2*CH_W+1)'(wa) * (2*CH_W+1)'(s);
    pd  = (2*CH_W+1)'(wd) * (2*CH_W+1)'(d);
    sum = {1'b0, ps[2*CH_W-1:CH_W]} + {1'b0, pd[2*CH_W-1:CH_W]};
    return sum[CH_W-1:0];
  endfunction

endpackage

>>> sv/cpab_front.sv
module cpab_front (
  input  logic [1:0]                      kind,
  input  logic [15:0]                     pos_x,
  input  logic [15:0]                     pos_y,
  input  logic [7:0]                      src_red,
  input  logic [7:0]                      src_green,
  input  logic [7:0]                      src_blue,
  input  logic [7:0]                      src_alpha,
  input  logic [8:0]                      screen_width,
  input  logic [8:0]                      screen_height,
  output cpab_pkg::pix_req_t              req
);
  import cpab_pkg::*;

  logic [CFG_W-1:0]         w_eff;
  logic [CFG_W-1:0]         h_eff;
  logic                     outside;
  logic [Y_W+CFG_W-1:0]     row_base;
  logic [Y_W+CFG_W:0]       addr_sum;

  // Sizes above the store act as the store size.
  assign w_eff = (32'(screen_width) > 32'(MAX_WIDTH)) ? CFG_W'(MAX_WIDTH) : screen_width;
  assign h_eff = (32'(screen_height) > 32'(MAX_HEIGHT)) ? CFG_W'(MAX_HEIGHT) : screen_height;

  // Clip test; a zero size clips everything.
  assign outside = (pos_x >= POS_W'(w_eff)) || (pos_y >= POS_W'(h_eff));

  // Linear address y * width + x. Only the low bits matter inside the window.
  assign row_base = (Y_W+CFG_W)'(pos_y[Y_W-1:0]) * (Y_W+CFG_W)'(w_eff);
  assign addr_sum = (Y_W+CFG_W+1)'(row_base) + (Y_W+CFG_W+1)'(pos_x[X_W-1:0]);

  // Classify the access. The unused kind behaves as a read.
  always_comb begin
    req.addr  = ADDR_W'(addr_sum);
    req.red   = src_red;
    req.green = src_green;
    req.blue  = src_blue;
    req.alpha = src_alpha;
    if (outside) begin
      req.op = OP_CLIP;
    end else begin
      case (kind)
        KIND_SET:   req.op = OP_SET;
        KIND_BLEND: req.op = OP_BLEND;
        KIND_READ:  req.op = OP_READ;
        default:    req.op = OP_READ;
      endcase
    end
  end

endmodule

>>> sv/cpab_queue.sv
module cpab_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  cpab_pkg::pix_req_t   push_data,
  output logic                 full,
  input  logic                 pop,
  output cpab_pkg::pix_req_t   head,
  output logic                 empty
);
  import cpab_pkg::*;

  pix_req_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

>>> sv/cpab_back.sv
module cpab_back (
  input  logic                 clk,
  input  logic                 rst,
  input  cpab_pkg::pix_req_t   head,
  input  logic                 q_empty,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 clipped,
  output logic [7:0]           out_red,
  output logic [7:0]           out_green,
  output logic [7:0]           out_blue,
  output logic [7:0]           out_alpha
);
  import cpab_pkg::*;

  back_state_t         state;
  back_state_t         state_next;
  back_ctl_t           ctl;
  pix_req_t            cur;
  logic [PIX_W-1:0]    mem [DEPTH];
  logic [PIX_W-1:0]    rdata;
  logic [PIX_W-1:0]    result;
  logic                result_clip;
  logic                do_write;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (!q_empty) state_next = ST_LOOK;
      end
      ST_LOOK: state_next = ST_MIX;
      ST_MIX:  state_next = ST_OUT;
      ST_OUT: begin
        if (out_ready) state_next = q_empty ? ST_IDLE : ST_LOOK;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    ctl = '0;
    case (state)
      ST_IDLE: ctl.pop    = !q_empty;
      ST_LOOK: ctl.mem_rd = 1'b1;
      ST_MIX:  ctl.update = 1'b1;
      ST_OUT: begin
        ctl.show = 1'b1;
        ctl.pop  = out_ready && !q_empty;
      end
      default: ctl = '0;
    endcase
  end

  assign q_pop     = ctl.pop;
  assign out_valid = ctl.show;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Current transaction, taken from the queue head.
  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      cur <= head;
    end
  end

  // Pixel after the access.
  always_comb begin
    result_clip = 1'b0;
    do_write    = 1'b0;
    case (cur.op)
      OP_SET: begin
        result   = {cur.red, cur.green, cur.blue, cur.alpha};
        do_write = 1'b1;
      end
      OP_BLEND: begin
        result = {mix_channel(cur.alpha, cur.red,   rdata[4*CH_W-1:3*CH_W]),
                  mix_channel(cur.alpha, cur.green, rdata[3*CH_W-1:2*CH_W]),
                  mix_channel(cur.alpha, cur.blue,  rdata[2*CH_W-1:CH_W]),
                  rdata[CH_W-1:0]};
        do_write = 1'b1;
      end
      OP_READ: result = rdata;
      default: begin
        result      = '0;
        result_clip = 1'b1;
      end
    endcase
  end

  // Frame store: registered read, single write port.
  always_ff @(posedge clk) begin
    if (ctl.mem_rd) begin
      rdata <= mem[cur.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.update && do_write) begin
      mem[cur.addr] <= result;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (ctl.update) begin
      clipped   <= result_clip;
      out_red   <= result[4*CH_W-1:3*CH_W];
      out_green <= result[3*CH_W-1:2*CH_W];
      out_blue  <= result[2*CH_W-1:CH_W];
      out_alpha <= result[CH_W-1:0];
    end
  end

  // A clipped result carries no color.
  a_clip_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && clipped |-> (out_red == '0) && (out_green == '0) &&
                             (out_blue == '0) && (out_alpha == '0))
    else $error("clipped result with nonzero color");

  // Each update is presented in the following cycle.
  a_mix_to_out: assert property (@(posedge clk) disable iff (rst)
    state == ST_MIX |=> state == ST_OUT)
    else $error("update not followed by output");

  // A popped transaction starts its store lookup next.
  a_pop_look: assert property (@(posedge clk) disable iff (rst)
    ctl.pop |=> state == ST_LOOK)
    else $error("popped transaction not looked up");

endmodule

>>> sv/clipped_pixel_alpha_blend_store_unit.sv
// Channel   Handshake              Payload
// input     in_valid / in_ready    kind, pos_x, pos_y, src_red/green/blue/alpha
// output    out_valid / out_ready  clipped, out_red/green/blue/alpha
// config    APB psel/penable       paddr 0 width, 4 height; pwdata, prdata
//
// The front clips and computes y*width+x combinationally into a two-entry queue.
// The back takes one transaction at a time: store read, update, output, and
// the next one is popped only when the output is taken.
// The steps follow from the frame store's registered read followed by the write.
// Reset clears control state and sets both sizes to 256; the store is not cleared.
// The queue keeps taking input while a result waits on out_ready, until it is full.
module clipped_pixel_alpha_blend_store_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [1:0]   kind,
  input  logic [15:0]  pos_x,
  input  logic [15:0]  pos_y,
  input  logic [7:0]   src_red,
  input  logic [7:0]   src_green,
  input  logic [7:0]   src_blue,
  input  logic [7:0]   src_alpha,
  output logic         out_valid,
  input  logic         out_ready,
  output logic         clipped,
  output logic [7:0]   out_red,
  output logic [7:0]   out_green,
  output logic [7:0]   out_blue,
  output logic [7:0]   out_alpha,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import cpab_pkg::*;

  logic [CFG_W-1:0]  screen_width;
  logic [CFG_W-1:0]  screen_height;
  pix_req_t          req;
  pix_req_t          head;
  logic              q_full;
  logic              q_empty;
  logic              q_pop;
  logic              cfg_wr;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= SIZE_RESET;
      screen_height <= SIZE_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_WIDTH:  screen_width  <= pwdata[CFG_W-1:0];
        REG_HEIGHT: screen_height <= pwdata[CFG_W-1:0];
        default:    screen_width  <= screen_width;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_WIDTH:  prdata = APB_DW'(screen_width);
      REG_HEIGHT: prdata = APB_DW'(screen_height);
      default:    prdata = '0;
    endcase
  end

  // Input side: classify and queue.
  assign in_ready = !q_full;

  cpab_front u_front (
    .kind          (kind),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .src_red       (src_red),
    .src_green     (src_green),
    .src_blue      (src_blue),
    .src_alpha     (src_alpha),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .req           (req)
  );

  cpab_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid && in_ready),
    .push_data (req),
    .full      (q_full),
    .pop       (q_pop),
    .head      (head),
    .empty     (q_empty)
  );

  // Execution side: store access and result.
  cpab_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .clipped   (clipped),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .out_alpha (out_alpha)
  );

endmodule
